// ===== rtl/core/rlms_pkg.sv =====
// Shared types, constants and color tables for the RGB lamp mode sequencer.
package rlms_pkg;

    // Limits and fixed values
    localparam logic [7:0] HOLD_MAX      = 8'd200;
    localparam logic [7:0] PWM_TOP       = 8'd254;
    localparam logic [5:0] FADE_LAST     = 6'd24;
    localparam logic [5:0] FIXED_LO_LAST = 6'd36;
    localparam logic [5:0] STEP_LAST     = 6'd48;
    localparam logic [3:0] MODE_OFF      = 4'd0;
    localparam logic [3:0] MODE_FIRST    = 4'd1;
    localparam logic [3:0] MODE_RAINBOW  = 4'd8;
    localparam logic [7:0] CLICK_MIN_RST = 8'd40;
    localparam logic [7:0] DWELL_RST     = 8'd250;

    // Request kinds
    localparam logic REQ_PWM = 1'b0;
    localparam logic REQ_MS  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_CLICK_MIN = 1'b0;
    localparam logic CFG_DWELL     = 1'b1;

    // Color codes: bit 2 red, bit 1 green, bit 0 blue; KEEP leaves targets alone
    localparam logic [3:0] COLOR_WHITE = 4'd7;
    localparam logic [3:0] COLOR_KEEP  = 4'd8;

    typedef struct packed {
        logic [7:0] click_min_ms;
        logic [7:0] dwell_ms;
    } cfg_t;

    typedef struct packed {
        logic [3:0] mode;
        logic       led_enable;
        logic [7:0] hold_count;
        logic [7:0] level_red;
        logic [7:0] level_green;
        logic [7:0] level_blue;
        logic [7:0] target_red;
        logic [7:0] target_green;
        logic [7:0] target_blue;
        logic [5:0] rainbow_step;
        logic [7:0] dwell_count;
        logic [7:0] pwm_count;
    } state_t;

    typedef struct packed {
        logic       red_on;
        logic       green_on;
        logic       blue_on;
        logic [3:0] lamp_mode;
        logic       sleep_request;
    } result_t;

    // Fade target color for rainbow steps 0..24
    function automatic logic [3:0] fade_target(input logic [5:0] step);
        logic [3:0] code;
        code = COLOR_KEEP;
        case (step)
            6'd1, 6'd7, 6'd16, 6'd22:                 code = 4'd3;
            6'd2, 6'd8, 6'd17, 6'd23:                 code = 4'd1;
            6'd3, 6'd6, 6'd9, 6'd12, 6'd18, 6'd24:    code = 4'd0;
            6'd4, 6'd10, 6'd14, 6'd20:                code = 4'd6;
            6'd5, 6'd11, 6'd13, 6'd19:                code = 4'd4;
            6'd15, 6'd21:                             code = 4'd7;
            default:                                  code = COLOR_KEEP;
        endcase
        return code;
    endfunction

    // Fixed color for rainbow steps 25..48
    function automatic logic [2:0] fixed_color(input logic [5:0] step);
        logic [2:0] code;
        code = 3'd0;
        case (step) inside
            6'd25, 6'd28, 6'd31, 6'd34: code = 3'd4;
            6'd26, 6'd29, 6'd32, 6'd35: code = 3'd2;
            6'd27, 6'd30, 6'd33, 6'd36: code = 3'd1;
            6'd37, 6'd40, 6'd43, 6'd46: code = 3'd6;
            6'd38, 6'd41, 6'd44, 6'd47: code = 3'd3;
            6'd39, 6'd42, 6'd45, 6'd48: code = 3'd5;
            default:                    code = 3'd0;
        endcase
        return code;
    endfunction

    // Color for the fixed modes 0..7
    function automatic logic [2:0] mode_color(input logic [2:0] mode);
        logic [2:0] code;
        code = 3'd0;
        case (mode)
            3'd1:    code = 3'd4;
            3'd2:    code = 3'd2;
            3'd3:    code = 3'd1;
            3'd4:    code = 3'd6;
            3'd5:    code = 3'd3;
            3'd6:    code = 3'd5;
            3'd7:    code = 3'd7;
            default: code = 3'd0;
        endcase
        return code;
    endfunction

    // Step a level one count toward its target
    function automatic logic [7:0] approach(input logic [7:0] v, input logic [7:0] t);
        logic [7:0] r;
        r = v;
        if (v > t) begin
            r = v - 8'd1;
        end else if (v < t) begin
            r = v + 8'd1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/rgb_lamp_mode_sequencer_core.sv =====
// Top level of the RGB lamp mode sequencer: state, config and result registers.
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    s_req_type, s_key_pressed
//  m_        out        m_valid/m_ready    m_red_on, m_green_on, m_blue_on,
//                                          m_lamp_mode, m_sleep_request
//  cfg_      in         cfg_wr_en          cfg_index, cfg_wr_data
//
// One request per clock while m_ready does not stall: state updates at the accepting
// edge, and the result appears on m_ the next cycle.
// s_ready is high whenever the result register is empty or being taken, so a
// stall on m_ holds one result and blocks input only while m_ready stays low.
// Reset (aresetn low, synchronous) clears the lamp state and the result valid
// flag and loads the config defaults; no clearing pass is needed.
module rgb_lamp_mode_sequencer_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_req_type,
    input  logic       s_key_pressed,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_red_on,
    output logic       m_green_on,
    output logic       m_blue_on,
    output logic [3:0] m_lamp_mode,
    output logic       m_sleep_request,
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wr_data
);

    rlms_pkg::state_t  state_reg;
    rlms_pkg::state_t  state_next;
    rlms_pkg::cfg_t    cfg_reg;
    rlms_pkg::result_t result_next;
    rlms_pkg::result_t result_reg;
    logic              valid_reg;
    logic              accept;

    assign s_ready = !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    rlms_step u_step (
        .state       (state_reg),
        .cfg         (cfg_reg),
        .req_type    (s_req_type),
        .key_pressed (s_key_pressed),
        .state_next  (state_next),
        .result      (result_next)
    );

    // Hold config; write on enable
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.click_min_ms <= rlms_pkg::CLICK_MIN_RST;
            cfg_reg.dwell_ms     <= rlms_pkg::DWELL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rlms_pkg::CFG_CLICK_MIN: cfg_reg.click_min_ms <= cfg_wr_data;
                rlms_pkg::CFG_DWELL:     cfg_reg.dwell_ms     <= cfg_wr_data;
                default:                 cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Advance lamp state on each accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // Result valid: set on accept, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= accept;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid         = valid_reg;
    assign m_red_on        = result_reg.red_on;
    assign m_green_on      = result_reg.green_on;
    assign m_blue_on       = result_reg.blue_on;
    assign m_lamp_mode     = result_reg.lamp_mode;
    assign m_sleep_request = result_reg.sleep_request;

endmodule

// ===== rtl/core/rlms_step.sv =====
// Next-state and result logic for one pwm or millisecond request.
module rlms_step (
    input  rlms_pkg::state_t  state,
    input  rlms_pkg::cfg_t    cfg,
    input  logic              req_type,
    input  logic              key_pressed,
    output rlms_pkg::state_t  state_next,
    output rlms_pkg::result_t result
);

    rlms_pkg::state_t nx;
    logic             click;
    logic [4:0]       mode_inc;
    logic [5:0]       step_inc;
    logic [7:0]       dwell_inc;
    logic [3:0]       fade_code;
    logic [2:0]       color;
    logic             led_r;
    logic             led_g;
    logic             led_b;

    always_comb begin
        nx        = state;
        click     = 1'b0;
        mode_inc  = 5'd0;
        step_inc  = 6'd0;
        dwell_inc = 8'd0;
        fade_code = rlms_pkg::COLOR_KEEP;
        color     = 3'd0;
        led_r     = 1'b0;
        led_g     = 1'b0;
        led_b     = 1'b0;

        if (req_type == rlms_pkg::REQ_PWM) begin
            // When enabled, compare levels against the slot counter and advance it
            if (state.led_enable) begin
                led_r = state.level_red   > state.pwm_count;
                led_g = state.level_green > state.pwm_count;
                led_b = state.level_blue  > state.pwm_count;
                nx.pwm_count = (state.pwm_count >= rlms_pkg::PWM_TOP) ?
                               8'd0 : state.pwm_count + 8'd1;
            end
        end else begin
            // Debounce: saturate hold count, click on release
            if (key_pressed) begin
                if (state.hold_count < rlms_pkg::HOLD_MAX) begin
                    nx.hold_count = state.hold_count + 8'd1;
                end
            end else begin
                click         = state.hold_count >= cfg.click_min_ms;
                nx.hold_count = 8'd0;
            end

            // Advance mode on a click, enter rainbow at its first step
            if (click) begin
                mode_inc = {1'b0, state.mode} + 5'd1;
                nx.mode  = (mode_inc > {1'b0, rlms_pkg::MODE_RAINBOW}) ?
                           rlms_pkg::MODE_OFF : mode_inc[3:0];
                if (nx.mode == rlms_pkg::MODE_RAINBOW) begin
                    nx.rainbow_step = 6'd1;
                    nx.level_red    = 8'hFF;
                    nx.level_green  = 8'hFF;
                    nx.level_blue   = 8'hFF;
                end
            end

            if (nx.mode == rlms_pkg::MODE_OFF) begin
                nx.led_enable = 1'b0;
            end else if (nx.mode < rlms_pkg::MODE_RAINBOW) begin
                // Fixed color modes
                if (nx.mode == rlms_pkg::MODE_FIRST) begin
                    nx.led_enable = 1'b1;
                end
                color          = rlms_pkg::mode_color(nx.mode[2:0]);
                nx.level_red   = {8{color[2]}};
                nx.level_green = {8{color[1]}};
                nx.level_blue  = {8{color[0]}};
            end else if (nx.rainbow_step <= rlms_pkg::FADE_LAST) begin
                // Fade phase: load target, move levels one count toward it
                fade_code = rlms_pkg::fade_target(nx.rainbow_step);
                if (fade_code != rlms_pkg::COLOR_KEEP) begin
                    nx.target_red   = {8{fade_code[2]}};
                    nx.target_green = {8{fade_code[1]}};
                    nx.target_blue  = {8{fade_code[0]}};
                end
                nx.level_red   = rlms_pkg::approach(nx.level_red,   nx.target_red);
                nx.level_green = rlms_pkg::approach(nx.level_green, nx.target_green);
                nx.level_blue  = rlms_pkg::approach(nx.level_blue,  nx.target_blue);
                if (nx.level_red == nx.target_red && nx.level_green == nx.target_green &&
                    nx.level_blue == nx.target_blue) begin
                    step_inc        = nx.rainbow_step + 6'd1;
                    nx.rainbow_step = step_inc;
                    if (step_inc == 6'd1 || step_inc == 6'd4 || step_inc == 6'd7 ||
                        step_inc == 6'd10) begin
                        nx.level_red   = 8'hFF;
                        nx.level_green = 8'hFF;
                        nx.level_blue  = 8'hFF;
                    end
                end
            end else begin
                // Fixed phase: show the step color, dwell, then advance
                if (nx.rainbow_step <= rlms_pkg::STEP_LAST) begin
                    color          = rlms_pkg::fixed_color(nx.rainbow_step);
                    nx.level_red   = {8{color[2]}};
                    nx.level_green = {8{color[1]}};
                    nx.level_blue  = {8{color[0]}};
                end
                dwell_inc      = state.dwell_count + 8'd1;
                nx.dwell_count = dwell_inc;
                if (dwell_inc > cfg.dwell_ms) begin
                    nx.dwell_count  = 8'd0;
                    step_inc        = nx.rainbow_step + 6'd1;
                    nx.rainbow_step = (step_inc > rlms_pkg::STEP_LAST) ? 6'd1 : step_inc;
                end
            end
        end
    end

    assign state_next           = nx;
    assign result.red_on        = led_r;
    assign result.green_on      = led_g;
    assign result.blue_on       = led_b;
    assign result.lamp_mode     = nx.mode;
    assign result.sleep_request = (nx.mode == rlms_pkg::MODE_OFF) && (nx.hold_count == 8'd0);

endmodule
